### src/asbc_pkg.sv
`timescale 1ns / 1ps

package asbc_pkg;

    localparam int MAX_COLLIDERS_DEF = 64;

    // Wide coordinate: a 32-bit coordinate plus one velocity plus the skin margin
    localparam int COORD_W = 34;

    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-3:0] REG_SKIN_MARGIN = 1'b0;
    localparam logic [15:0] SKIN_MARGIN_RESET = 16'd1311;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_MOVE  = 2'd2;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_min_z;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
    } cmd_item_t;

    typedef struct packed {
        logic signed [31:0] allowed_x;
        logic signed [31:0] allowed_y;
        logic signed [31:0] allowed_z;
        logic               status;
    } res_item_t;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] min_z;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic signed [31:0] max_z;
    } collider_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_BOX,
        ST_SCAN,
        ST_APPLY,
        ST_DONE
    } state_t;

    function automatic logic signed [COORD_W-1:0] widen(input logic signed [31:0] v);
        return {{(COORD_W-32){v[31]}}, v};
    endfunction

endpackage

### src/axis_separated_box_collision.sv
`timescale 1ns / 1ps

// Axis-separated box collision resolver. Holds up to MAX_COLLIDERS static boxes in
// an on-chip memory and answers each command item with one result item. Add and
// clear pass from acceptance through the EXEC and DONE states to the result; a move
// tests X, then Z, then Y, each test scanning the stored boxes one per cycle through
// a single six-way compare unit fed by the memory's registered read port and ending
// early on a hit. The command port is not ready while an item is in work; a
// finished result waits in an output register so the next command can be taken
// before it is collected. skin_margin (unsigned Q0.16, reset 1311) is written
// through the APB port at address 0.
module axis_separated_box_collision #(
    parameter int MAX_COLLIDERS = asbc_pkg::MAX_COLLIDERS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  asbc_pkg::cmd_item_t           cmd,
    output logic                          res_valid,
    input  logic                          res_ready,
    output asbc_pkg::res_item_t           res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [asbc_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int CW    = asbc_pkg::COORD_W;
    localparam int CNT_W = $clog2(MAX_COLLIDERS + 1);
    localparam int IDX_W = (MAX_COLLIDERS > 1) ? $clog2(MAX_COLLIDERS) : 1;

    asbc_pkg::state_t    state_reg, state_next;
    asbc_pkg::cmd_item_t item_reg;
    asbc_pkg::res_item_t res_reg;
    asbc_pkg::collider_t mem [MAX_COLLIDERS];
    asbc_pkg::collider_t rd_data_reg;

    logic [15:0]          skin_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic                 pend_reg;
    logic                 blocked_reg;
    logic                 status_reg;
    logic                 res_valid_reg;
    logic [1:0]           axis_reg;
    logic signed [CW-1:0] p_lo_reg [3];
    logic signed [CW-1:0] p_hi_reg [3];
    logic signed [CW-1:0] t_lo_reg [3];
    logic signed [CW-1:0] t_hi_reg [3];
    logic signed [31:0]   vel_reg  [3];

    logic                 full;
    logic                 issue;
    logic                 overlap;
    logic                 hit_now;
    logic                 wr_en;
    logic                 cfg_wr;
    logic                 out_free;
    logic signed [CW-1:0] skin_w;
    logic signed [CW-1:0] step_w;

    assign full     = (count_reg >= CNT_W'(MAX_COLLIDERS));
    assign issue    = (idx_reg < count_reg);
    assign out_free = !res_valid_reg || res_ready;
    assign skin_w   = CW'({1'b0, skin_reg});
    assign step_w   = blocked_reg ? '0 : asbc_pkg::widen(vel_reg[axis_reg]);
    assign wr_en    = (state_reg == asbc_pkg::ST_EXEC) &&
                      (item_reg.command == asbc_pkg::CMD_ADD) && !full;
    assign cfg_wr   = psel && penable && pwrite && pready;

    // Shared compare unit: inclusive overlap of the test box with one stored box
    assign overlap = (t_lo_reg[0] <= asbc_pkg::widen(rd_data_reg.max_x)) &&
                     (t_hi_reg[0] >= asbc_pkg::widen(rd_data_reg.min_x)) &&
                     (t_lo_reg[1] <= asbc_pkg::widen(rd_data_reg.max_y)) &&
                     (t_hi_reg[1] >= asbc_pkg::widen(rd_data_reg.min_y)) &&
                     (t_lo_reg[2] <= asbc_pkg::widen(rd_data_reg.max_z)) &&
                     (t_hi_reg[2] >= asbc_pkg::widen(rd_data_reg.min_z));
    assign hit_now = pend_reg && overlap;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            asbc_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                    state_next = asbc_pkg::ST_EXEC;
            end
            asbc_pkg::ST_EXEC:
            begin
                if (item_reg.command == asbc_pkg::CMD_MOVE)
                    state_next = asbc_pkg::ST_BOX;
                else
                    state_next = asbc_pkg::ST_DONE;
            end
            asbc_pkg::ST_BOX:
                state_next = asbc_pkg::ST_SCAN;
            asbc_pkg::ST_SCAN:
            begin
                if (hit_now || (!issue && !pend_reg))
                    state_next = asbc_pkg::ST_APPLY;
            end
            asbc_pkg::ST_APPLY:
            begin
                if (axis_reg == asbc_pkg::AX_Y)
                    state_next = asbc_pkg::ST_DONE;
                else
                    state_next = asbc_pkg::ST_BOX;
            end
            asbc_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = asbc_pkg::ST_IDLE;
            end
            default:
                state_next = asbc_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd_ready = (state_reg == asbc_pkg::ST_IDLE);
        res_valid = res_valid_reg;
        res       = res_reg;
        pready    = 1'b1;
        prdata    = '0;
        if (paddr[asbc_pkg::PADDR_W-1:2] == asbc_pkg::REG_SKIN_MARGIN)
            prdata = {16'd0, skin_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= asbc_pkg::ST_IDLE;
            count_reg     <= '0;
            skin_reg      <= asbc_pkg::SKIN_MARGIN_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr && (paddr[asbc_pkg::PADDR_W-1:2] == asbc_pkg::REG_SKIN_MARGIN))
                skin_reg <= pwdata[15:0];
            if (state_reg == asbc_pkg::ST_EXEC)
            begin
                if (wr_en)
                    count_reg <= count_reg + CNT_W'(1);
                else if (item_reg.command == asbc_pkg::CMD_CLEAR)
                    count_reg <= '0;
            end
            if ((state_reg == asbc_pkg::ST_DONE) && out_free)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Collider memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[count_reg[IDX_W-1:0]] <= '{min_x: item_reg.box_min_x,
                                           min_y: item_reg.box_min_y,
                                           min_z: item_reg.box_min_z,
                                           max_x: item_reg.box_max_x,
                                           max_y: item_reg.box_max_y,
                                           max_z: item_reg.box_max_z};
        if ((state_reg == asbc_pkg::ST_SCAN) && issue)
            rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            asbc_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                    item_reg <= cmd;
            end
            asbc_pkg::ST_EXEC:
            begin
                status_reg  <= (item_reg.command == asbc_pkg::CMD_ADD) && full;
                axis_reg    <= asbc_pkg::AX_X;
                p_lo_reg[0] <= asbc_pkg::widen(item_reg.box_min_x);
                p_lo_reg[1] <= asbc_pkg::widen(item_reg.box_min_y);
                p_lo_reg[2] <= asbc_pkg::widen(item_reg.box_min_z);
                p_hi_reg[0] <= asbc_pkg::widen(item_reg.box_max_x);
                p_hi_reg[1] <= asbc_pkg::widen(item_reg.box_max_y);
                p_hi_reg[2] <= asbc_pkg::widen(item_reg.box_max_z);
                if (item_reg.command == asbc_pkg::CMD_MOVE)
                begin
                    vel_reg[0] <= item_reg.vel_x;
                    vel_reg[1] <= item_reg.vel_y;
                    vel_reg[2] <= item_reg.vel_z;
                end
                else
                begin
                    vel_reg[0] <= '0;
                    vel_reg[1] <= '0;
                    vel_reg[2] <= '0;
                end
            end
            asbc_pkg::ST_BOX:
            begin
                // Shift the tested axis, shrink the other two by the skin
                for (int k = 0; k < 3; k++)
                begin
                    if (axis_reg == 2'(k))
                    begin
                        t_lo_reg[k] <= p_lo_reg[k] + asbc_pkg::widen(vel_reg[k]);
                        t_hi_reg[k] <= p_hi_reg[k] + asbc_pkg::widen(vel_reg[k]);
                    end
                    else
                    begin
                        t_lo_reg[k] <= p_lo_reg[k] + skin_w;
                        t_hi_reg[k] <= p_hi_reg[k] - skin_w;
                    end
                end
                idx_reg     <= '0;
                pend_reg    <= 1'b0;
                blocked_reg <= 1'b0;
            end
            asbc_pkg::ST_SCAN:
            begin
                pend_reg <= issue;
                if (issue)
                    idx_reg <= idx_reg + CNT_W'(1);
                if (hit_now)
                    blocked_reg <= 1'b1;
            end
            asbc_pkg::ST_APPLY:
            begin
                if (blocked_reg)
                    vel_reg[axis_reg] <= '0;
                p_lo_reg[axis_reg] <= p_lo_reg[axis_reg] + step_w;
                p_hi_reg[axis_reg] <= p_hi_reg[axis_reg] + step_w;
                // Axis order: X, then Z, then Y
                if (axis_reg == asbc_pkg::AX_X)
                    axis_reg <= asbc_pkg::AX_Z;
                else
                    axis_reg <= asbc_pkg::AX_Y;
            end
            asbc_pkg::ST_DONE:
            begin
                if (out_free)
                    res_reg <= '{allowed_x: vel_reg[0],
                                 allowed_y: vel_reg[1],
                                 allowed_z: vel_reg[2],
                                 status:    status_reg};
            end
            default:
            begin
            end
        endcase
    end

endmodule

### src/asbc_checker.sv
`timescale 1ns / 1ps

module asbc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cmd_valid,
    input logic                         cmd_ready,
    input logic                         res_valid,
    input logic                         res_ready,
    input asbc_pkg::res_item_t          res,
    input logic                         pready
);

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // Busy after taking an item
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("ready right after accepting an item");

    // A new result only follows a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(!cmd_ready))
        else $error("result appeared without work");

    // A dropped add reports zero velocity
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status |->
            (res.allowed_x == 32'sd0) && (res.allowed_y == 32'sd0) &&
            (res.allowed_z == 32'sd0))
        else $error("dropped add with nonzero velocity");

    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind axis_separated_box_collision asbc_checker u_asbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .pready    (pready)
);
